// ===== rtl/core/mpsd_pkg.sv =====
// shared types and constants for the masked patch mean squared distance block
// no dependencies; imported by every module under rtl/core
package mpsd_pkg;

  // pixel and window widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SQ_W    = 2 * PIX_W;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned DIST_W  = 16;

  // nominal window geometry, for reference by users of the block
  localparam int unsigned MAX_RADIUS   = 7;
  localparam int unsigned WINDOW_PAIRS = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

  // window queue between accumulator and divider
  localparam int unsigned QUEUE_DEPTH = 4;

  // divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_MAX_DIST  = 1'b0;
  localparam logic REG_MIN_COUNT = 1'b1;

  localparam logic [DIST_W-1:0] MAX_DIST_RST  = '1;
  localparam logic [CNT_W-1:0]  MIN_COUNT_RST = CNT_W'(1);

  // one finished window, as handed from accumulator to divider
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             center_hole;
  } win_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } bk_state_e;

endpackage

// ===== rtl/core/mpsd_front.sv =====
// accumulator front end: squares pixel differences and sums them per window
// depends on mpsd_pkg; pushes one win_t per window into the queue
module mpsd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mpsd_pkg::PIX_W-1:0]      src_pixel_i,
  input  logic [mpsd_pkg::PIX_W-1:0]      tgt_pixel_i,
  input  logic                            src_hole_i,
  input  logic                            tgt_hole_i,
  input  logic                            is_center_i,
  input  logic                            last_i,
  input  logic                            q_afull_i,
  output logic                            push_o,
  output mpsd_pkg::win_t                  push_data_o
);
  import mpsd_pkg::*;

  logic               accept;
  logic [PIX_W-1:0]   diff;
  logic               v_q;
  logic [SQ_W-1:0]    sq_q;
  logic               use_q;
  logic               chole_q;
  logic               last_q;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               hole_q, hole_d;
  logic [SUM_W:0]     sum_ext;

  // one slot of slack covers the request sitting in the square stage
  assign in_stall_o = q_afull_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (src_pixel_i >= tgt_pixel_i) begin
      diff = src_pixel_i - tgt_pixel_i;
    end else begin
      diff = tgt_pixel_i - src_pixel_i;
    end
  end

  // square stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q    <= diff * diff;
      use_q   <= !src_hole_i && !tgt_hole_i;
      chole_q <= is_center_i && tgt_hole_i;
      last_q  <= last_i;
    end
  end

  // saturating accumulate
  always_comb begin
    sum_ext = {1'b0, sum_q} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_q};
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    if (use_q) begin
      sum_d = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      if (cnt_q != {CNT_W{1'b1}}) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    hole_d = hole_q || chole_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      hole_q <= 1'b0;
    end else if (v_q) begin
      if (last_q) begin
        sum_q  <= '0;
        cnt_q  <= '0;
        hole_q <= 1'b0;
      end else begin
        sum_q  <= sum_d;
        cnt_q  <= cnt_d;
        hole_q <= hole_d;
      end
    end
  end

  assign push_o                  = v_q && last_q;
  assign push_data_o.sum         = sum_d;
  assign push_data_o.count       = cnt_d;
  assign push_data_o.center_hole = hole_d;

endmodule

// ===== rtl/core/mpsd_queue.sv =====
// short queue of finished windows between accumulator and divider
// depends on mpsd_pkg for win_t
module mpsd_queue #(
  parameter int unsigned DEPTH = mpsd_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpsd_pkg::win_t push_data_i,
  output logic           afull_o,
  output logic           valid_o,
  input  logic           pop_i,
  output mpsd_pkg::win_t pop_data_o
);
  import mpsd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  win_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [LVL_W-1:0] lvl_q;
  logic             do_pop;

  assign valid_o    = lvl_q != '0;
  assign afull_o    = lvl_q >= LVL_W'(DEPTH - 1);
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      lvl_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        lvl_q <= lvl_q + 1'b1;
      end else if (!push_i && do_pop) begin
        lvl_q <= lvl_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/mpsd_back.sv =====
// divider back end: checks each window, divides sum by count, holds the result
// depends on mpsd_pkg; takes windows from mpsd_queue
module mpsd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  mpsd_pkg::win_t                q_data_i,
  output logic                          pop_o,
  input  logic [mpsd_pkg::DIST_W-1:0]   max_distance_i,
  input  logic [mpsd_pkg::CNT_W-1:0]    min_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mpsd_pkg::DIST_W-1:0]   mean_sq_distance_o,
  output logic [mpsd_pkg::CNT_W-1:0]    used_count_o,
  output logic                          rejected_o
);
  import mpsd_pkg::*;

  bk_state_e         state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W:0]    rem_sub;
  logic [CNT_W-1:0]  need;
  logic              rej;
  logic              out_free;
  logic              load_rej;
  logic              load_div;
  logic              start_div;
  logic              out_valid_q;
  logic [DIST_W-1:0] mean_q;
  logic [CNT_W-1:0]  used_q;
  logic              rej_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    need = (min_count_i == '0) ? CNT_W'(1) : min_count_i;
    rej  = q_data_i.center_hole || (q_data_i.count < need);
  end

  // restoring divider step
  always_comb begin
    rem_sh  = {rem_q, dvd_q[SUM_W-1]};
    ge      = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    load_rej  = 1'b0;
    load_div  = 1'b0;
    start_div = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (rej) begin
            if (out_free) begin
              pop_o    = 1'b1;
              load_rej = 1'b1;
            end
          end else begin
            pop_o     = 1'b1;
            start_div = 1'b1;
            state_d   = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        if (step_q == '0) begin
          state_d = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_div = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_div) begin
      dvd_q  <= q_data_i.sum;
      div_q  <= q_data_i.count;
      rem_q  <= '0;
      step_q <= STEP_W'(DIV_STEPS - 1);
    end else if (state_q == BK_DIV) begin
      dvd_q  <= {dvd_q[SUM_W-2:0], ge};
      rem_q  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      step_q <= step_q - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_rej || load_div) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_rej) begin
      mean_q <= max_distance_i;
      rej_q  <= 1'b1;
      used_q <= q_data_i.count;
    end else if (load_div) begin
      mean_q <= (dvd_q[SUM_W-1:DIST_W] != '0) ? {DIST_W{1'b1}} : dvd_q[DIST_W-1:0];
      rej_q  <= 1'b0;
      used_q <= div_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mean_sq_distance_o = mean_q;
  assign used_count_o       = used_q;
  assign rejected_o         = rej_q;

  a_no_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rejected_o |-> used_count_o != '0)
    else $error("accepted window with zero pairs");

  a_count_meets_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rejected_o |-> used_count_o >= min_count_i)
    else $error("accepted window below minimum count");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == BK_IDLE && q_valid_i)
    else $error("window taken while divider busy");

  a_div_runs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV && step_q == '0 |=> state_q == BK_HOLD)
    else $error("divider did not finish after last step");

endmodule

// ===== rtl/core/masked_patch_mean_sq_distance.sv =====
// top level of the masked patch mean squared distance block
// depends on mpsd_pkg, mpsd_front, mpsd_queue, mpsd_back
//
// usage:
//   input channel (in_valid_i / in_stall_o) takes one pixel pair per cycle:
//   source and target grey level, a hole flag for each, a centre flag and a
//   last flag that closes the window. pairs with a hole on either side are
//   skipped; the rest add their squared difference to the window sum.
//   output channel (out_valid_o / out_stall_i) gives one request per window:
//   sum / count, saturated to 16 bits, or max_distance when the centre target
//   pixel was a hole or fewer than min_count pairs were usable.
// a rejected window passes the square stage, the window queue and the output
//   register; a divided one also goes through the bit-serial divider
// pairs stream at one per cycle while in_stall_o is low; the divider works on
//   one window at a time, so short windows can fill the window queue, after
//   which in_stall_o rises
// a stalled result waits in the output register while the divider already
//   works on the next window
// reset clears all control state and the window accumulator; max_distance
//   comes up as 65535 and min_count as 1
module masked_patch_mean_sq_distance #(
  parameter int unsigned QUEUE_DEPTH = mpsd_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel pair channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mpsd_pkg::PIX_W-1:0]    src_pixel_i,
  input  logic [mpsd_pkg::PIX_W-1:0]    tgt_pixel_i,
  input  logic                          src_hole_i,
  input  logic                          tgt_hole_i,
  input  logic                          is_center_i,
  input  logic                          last_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mpsd_pkg::DIST_W-1:0]   mean_sq_distance_o,
  output logic [mpsd_pkg::CNT_W-1:0]    used_count_o,
  output logic                          rejected_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpsd_pkg::APB_AW-1:0]   paddr,
  input  logic [mpsd_pkg::APB_DW-1:0]   pwdata,
  output logic [mpsd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import mpsd_pkg::*;

  logic [DIST_W-1:0] max_distance_q;
  logic [CNT_W-1:0]  min_count_q;
  logic              cfg_wr;
  logic              push;
  win_t              push_data;
  logic              q_afull;
  logic              q_valid;
  logic              pop;
  win_t              pop_data;

  // registers sit at byte offsets 0 and 4; bit 2 picks one
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_distance_q <= MAX_DIST_RST;
      min_count_q    <= MIN_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_DIST) begin
        max_distance_q <= pwdata[DIST_W-1:0];
      end else begin
        min_count_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MIN_COUNT) begin
      prdata = {{(APB_DW - CNT_W){1'b0}}, min_count_q};
    end else begin
      prdata = {{(APB_DW - DIST_W){1'b0}}, max_distance_q};
    end
  end

  // front: square and accumulate one pair per cycle unless stalled
  mpsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .src_pixel_i (src_pixel_i),
    .tgt_pixel_i (tgt_pixel_i),
    .src_hole_i  (src_hole_i),
    .tgt_hole_i  (tgt_hole_i),
    .is_center_i (is_center_i),
    .last_i      (last_i),
    .q_afull_i   (q_afull),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // finished windows wait here for the divider
  mpsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .afull_o     (q_afull),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  // back: reject check, bit-serial divide, output register
  mpsd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_data_i           (pop_data),
    .pop_o              (pop),
    .max_distance_i     (max_distance_q),
    .min_count_i        (min_count_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .mean_sq_distance_o (mean_sq_distance_o),
    .used_count_o       (used_count_o),
    .rejected_o         (rejected_o)
  );

endmodule

// ===== tb/sv/tb_masked_patch_mean_sq_distance.sv =====
`timescale 1ns / 100ps
// testbench for masked_patch_mean_sq_distance: directed and random pixel pair windows,
// each result checked against an in-bench distance predictor
// depends on mpsd_pkg and the rtl/core sources of the block
module tb_masked_patch_mean_sq_distance;
  import mpsd_pkg::*;

  localparam int unsigned SUM_LIMIT    = (1 << SUM_W) - 1;
  localparam int unsigned COUNT_LIMIT  = (1 << CNT_W) - 1;
  localparam int unsigned DIST_LIMIT   = (1 << DIST_W) - 1;
  // extra wait so that anything still in flight, such as a divided window, comes out
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned TIMEOUT_NS   = 2_000_000;

  localparam logic [APB_AW-1:0] ADDR_MAX_DIST  = {REG_MAX_DIST, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_MIN_COUNT = {REG_MIN_COUNT, 2'b00};

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  count;
    logic              rejected;
  } dist_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [PIX_W-1:0]    src_pixel_i = '0;
  logic [PIX_W-1:0]    tgt_pixel_i = '0;
  logic                src_hole_i  = 1'b0;
  logic                tgt_hole_i  = 1'b0;
  logic                is_center_i = 1'b0;
  logic                last_i      = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [DIST_W-1:0]   mean_sq_distance_o;
  logic [CNT_W-1:0]    used_count_o;
  logic                rejected_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // predictor copy of registers and window state
  logic [DIST_W-1:0]   cfg_max_dist    = MAX_DIST_RST;
  logic [CNT_W-1:0]    cfg_min_count   = MIN_COUNT_RST;
  logic [SUM_W-1:0]    win_sum         = '0;
  logic [CNT_W-1:0]    win_count       = '0;
  logic                win_center_hole = 1'b0;

  dist_result_t        expected_dist_q[$];
  int unsigned         pairs_sent   = 0;
  int unsigned         fail_count   = 0;
  bit                  src_idle_on  = 1'b1;
  bit                  sink_idle_on = 1'b1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  masked_patch_mean_sq_distance u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .src_pixel_i        (src_pixel_i),
    .tgt_pixel_i        (tgt_pixel_i),
    .src_hole_i         (src_hole_i),
    .tgt_hole_i         (tgt_hole_i),
    .is_center_i        (is_center_i),
    .last_i             (last_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .mean_sq_distance_o (mean_sq_distance_o),
    .used_count_o       (used_count_o),
    .rejected_o         (rejected_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  function automatic void compare_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // update the window with one accepted pair; a last pair queues the expected distance
  function automatic void predict_pair(input logic [PIX_W-1:0] sp, tp,
                                       input logic sh, th, ctr, lst);
    int unsigned s, t, diff, sq, need, quotient;
    dist_result_t res;
    s = sp;
    t = tp;
    // any centre pair with a target hole spoils the window
    if (ctr && th) win_center_hole = 1'b1;
    if (!sh && !th) begin
      diff = (s >= t) ? s - t : t - s;
      sq   = diff * diff;
      if (win_sum > SUM_LIMIT - sq) win_sum = SUM_W'(SUM_LIMIT);
      else win_sum = win_sum + SUM_W'(sq);
      if (win_count < COUNT_LIMIT) win_count = win_count + 1'b1;
    end
    if (lst) begin
      // min_count of zero behaves as one, and an empty window always rejects
      need         = (cfg_min_count == 0) ? 1 : cfg_min_count;
      res.count    = win_count;
      res.rejected = win_center_hole || (win_count == 0) || (win_count < need);
      if (res.rejected) begin
        res.distance = cfg_max_dist;
      end else begin
        quotient = win_sum / win_count;
        res.distance = (quotient > DIST_LIMIT) ? DIST_W'(DIST_LIMIT) : DIST_W'(quotient);
      end
      expected_dist_q.push_back(res);
      win_sum         = '0;
      win_count       = '0;
      win_center_hole = 1'b0;
    end
  endfunction

  // grey level biased toward the extremes
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // one pixel pair request, with an optional random gap ahead of it
  task automatic send_pair(input logic [PIX_W-1:0] sp, tp, input logic sh, th, ctr, lst);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    src_pixel_i <= sp;
    tgt_pixel_i <= tp;
    src_hole_i  <= sh;
    tgt_hole_i  <= th;
    is_center_i <= ctr;
    last_i      <= lst;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_pair(sp, tp, sh, th, ctr, lst);
    pairs_sent++;
  endtask

  // one window of len pairs; center_at past the end means no planned centre pair
  task automatic send_window(input int unsigned len, input int unsigned hole_pct,
                             input int unsigned center_at, input bit max_diff);
    logic [PIX_W-1:0] sp, tp;
    logic sh, th, ctr;
    for (int unsigned k = 0; k < len; k++) begin
      if (max_diff) begin
        sp = '1;
        tp = '0;
        sh = 1'b0;
        th = 1'b0;
      end else begin
        sp = rand_pixel();
        tp = rand_pixel();
        sh = ($urandom_range(0, 99) < hole_pct);
        th = ($urandom_range(0, 99) < hole_pct);
      end
      // a stray extra centre flag now and then
      ctr = (k == center_at) || ($urandom_range(0, 49) == 0);
      send_pair(sp, tp, sh, th, ctr, k == len - 1);
    end
  endtask

  task automatic run_random_windows(input int unsigned n_pairs);
    int unsigned stop_at, shape, holes, len;
    stop_at = pairs_sent + n_pairs;
    while (pairs_sent < stop_at) begin
      shape = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       holes = 0;
        1:       holes = 8;
        2:       holes = 30;
        default: holes = 85;
      endcase
      if (shape < 45) begin
        // patch-like window with its centre in the middle
        len = $urandom_range(9, 49);
        send_window(len, holes, len / 2, 1'b0);
      end else if (shape < 88) begin
        len = $urandom_range(1, 12);
        send_window(len, holes, $urandom_range(0, len), 1'b0);
      end else begin
        // nothing usable at all
        send_window($urandom_range(1, 3), 100, 0, 1'b0);
      end
    end
  endtask

  // stop sending and let every expected result come out
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_dist_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_reg(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_regs();
    logic [APB_DW-1:0] data;
    read_reg(ADDR_MAX_DIST, data);
    compare_field("max_distance readback", cfg_max_dist, data[DIST_W-1:0]);
    read_reg(ADDR_MIN_COUNT, data);
    compare_field("min_count readback", cfg_min_count, data[CNT_W-1:0]);
  endtask

  // write both registers with junk in the unused upper bits, then read them back
  task automatic set_registers(input logic [DIST_W-1:0] max_dist,
                               input logic [CNT_W-1:0] min_count);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[DIST_W-1:0] = max_dist;
    write_reg(ADDR_MAX_DIST, word);
    cfg_max_dist = max_dist;
    word = $urandom;
    word[CNT_W-1:0] = min_count;
    write_reg(ADDR_MIN_COUNT, word);
    cfg_min_count = min_count;
    check_regs();
  endtask

  task automatic test_reset_values();
    check_regs();
  endtask

  task automatic test_directed();
    // extremes of the grey levels
    send_pair(8'd0,   8'd255, 1'b0, 1'b0, 1'b0, 1'b1);
    send_pair(8'd255, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0);
    send_pair(8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b1);
    // centre target hole rejects
    send_pair(8'd7,   8'd9,   1'b0, 1'b1, 1'b1, 1'b0);
    send_pair(8'd1,   8'd2,   1'b0, 1'b0, 1'b0, 1'b1);
    // centre with only a source hole is just skipped
    send_pair(8'd10,  8'd3,   1'b1, 1'b0, 1'b1, 1'b0);
    send_pair(8'd20,  8'd24,  1'b0, 1'b0, 1'b0, 1'b1);
    // several centre pairs, the second one over a target hole
    send_pair(8'd3,   8'd3,   1'b0, 1'b0, 1'b1, 1'b0);
    send_pair(8'd5,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0);
    send_pair(8'd8,   8'd8,   1'b0, 1'b1, 1'b1, 1'b0);
    send_pair(8'd200, 8'd100, 1'b0, 1'b0, 1'b0, 1'b1);
    // no usable pairs
    send_pair(8'd255, 8'd255, 1'b1, 1'b1, 1'b0, 1'b1);
    // last pair is a hole and is skipped before the result
    send_pair(8'd5,   8'd2,   1'b0, 1'b0, 1'b0, 1'b0);
    send_pair(8'd9,   8'd9,   1'b1, 1'b0, 1'b0, 1'b1);
    // single centre pair, zero distance
    send_pair(8'd0,   8'd0,   1'b0, 1'b0, 1'b1, 1'b1);
    // three pairs with a difference of one each, an exact quotient of one
    send_pair(8'd128, 8'd127, 1'b0, 1'b0, 1'b0, 1'b0);
    send_pair(8'd127, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0);
    send_pair(8'd1,   8'd0,   1'b0, 1'b0, 1'b0, 1'b1);
    // centre pair with both holes, alone in its window
    send_pair(8'd255, 8'd0,   1'b1, 1'b1, 1'b1, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_min_count_zero();
    set_registers('0, '0);
    run_random_windows(120);
    wait_results_drained();
  endtask

  // count and sum both saturate; the saturated quotient clamps to the top
  task automatic test_overlong_window();
    set_registers(DIST_W'(DIST_LIMIT), CNT_W'(COUNT_LIMIT));
    send_window(270, 0, 135, 1'b1);
    send_window(3, 0, 1, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_full_window();
    set_registers(DIST_W'($urandom_range(0, DIST_LIMIT)), CNT_W'(WINDOW_PAIRS));
    send_window(WINDOW_PAIRS, 0, WINDOW_PAIRS / 2, 1'b0);
    send_window(WINDOW_PAIRS, 1, WINDOW_PAIRS / 2, 1'b0);
    run_random_windows(10);
    wait_results_drained();
  endtask

  task automatic test_config_sweep();
    set_registers(DIST_W'(DIST_LIMIT), CNT_W'(1));
    run_random_windows(220);
    wait_results_drained();
    set_registers(DIST_W'($urandom_range(0, DIST_LIMIT)), CNT_W'(5));
    run_random_windows(220);
    wait_results_drained();
    set_registers(DIST_W'($urandom_range(0, DIST_LIMIT)), CNT_W'($urandom_range(1, 12)));
    run_random_windows(220);
    wait_results_drained();
  endtask

  // back to back on both channels
  task automatic test_full_rate();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    set_registers(DIST_W'($urandom_range(0, DIST_LIMIT)), CNT_W'($urandom_range(1, 6)));
    run_random_windows(200);
    wait_results_drained();
  endtask

  // result side stall bursts
  initial begin : result_stall
    int unsigned left;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left != 0) left--;
      else if (sink_idle_on && $urandom_range(0, 5) == 0) left = $urandom_range(1, 11);
      out_stall_i <= (left != 0);
    end
  end

  always @(posedge clk_i) begin : result_check
    dist_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_dist_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual dist %0d count %0d rej %0d",
                 $time, mean_sq_distance_o, used_count_o, rejected_o);
        fail_count++;
      end else begin
        want = expected_dist_q.pop_front();
        compare_field("mean_sq_distance", want.distance, mean_sq_distance_o);
        compare_field("used_count", want.count, used_count_o);
        compare_field("rejected", want.rejected, rejected_o);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_min_count_zero();
    test_overlong_window();
    test_full_window();
    test_config_sweep();
    test_full_rate();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
